FILE: rtl/fsgs_pkg.sv
// Shared types and constants for the falling-sand grid step unit.
// Depends on nothing; imported by the top level and its checker.
package fsgs_pkg;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 8;
    localparam int CMD_W     = 2;
    localparam int ROW_W     = 7;
    localparam int COL_W     = 8;
    localparam int CELL_W    = 2;
    localparam int SEED_W    = 16;

    localparam logic [SEED_W-1:0] LFSR_ONE = SEED_W'(1);

    typedef enum logic [CELL_W-1:0] {
        CELL_EMPTY  = 2'd0,
        CELL_GROUND = 2'd1,
        CELL_SAND   = 2'd2,
        CELL_INERT  = 2'd3
    } cell_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_STEP  = 2'd2
    } cmd_t;

endpackage

FILE: rtl/falling_sand_grid_step_unit.sv
// Falling-sand grid step unit: grid storage, host cell access and generation sweep.
// Depends on fsgs_pkg.
//
// Usage: items arrive on the s_ channel (s_tuser carries the command, s_tdata the
// cell address and write value); each item gives exactly one transaction on the
// m_ channel carrying cell_out (the read cell, zero otherwise). The cfg_ channel
// writes the random seed and reloads the LFSR at once; it is always ready.
// A write passes through ST_OP and ST_RESP, a read through ST_OP, ST_READ and ST_RESP,
// a step through ST_SCAN, ST_DRAIN and ST_RESP. Items are taken one at a time;
// a step is bounded by the sweep, one grid slot per cycle through two banked
// single-write, dual-read grid memories plus two pad slots per row.
// A new item is accepted while a finished result still waits on the m_ channel;
// when the receiver stalls, the following result holds until the output drains.
// After reset the unit runs a clearing pass over every cell of the active grid
// bank; s_tready stays low until it completes, and the LFSR is loaded with 1.
module falling_sand_grid_step_unit
    import fsgs_pkg::*;
#(
    parameter int ROWS = 128,
    parameter int COLS = 256
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [6:0] row, [14:7] column, [16:15] cell_in, rest zero
    input  logic [CMD_W-1:0]     s_tuser,   // [1:0] cmd
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [1:0] cell_out, rest zero
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [SEED_W-1:0]    cfg_data
);

    localparam int DEPTH = ROWS * COLS;
    localparam int AW    = $clog2(DEPTH);
    localparam int RW    = $clog2(ROWS);
    localparam int SW    = $clog2(COLS + 2);
    localparam int LW    = $clog2(COLS);

    localparam logic [SW-1:0] SLOT_ONE   = SW'(1);
    localparam logic [SW-1:0] SLOT_TWO   = SW'(2);
    localparam logic [SW-1:0] SLOT_COLS  = SW'(COLS);
    localparam logic [SW-1:0] SLOT_LAST  = SW'(COLS + 1);
    localparam logic [RW-1:0] ROW_LAST   = RW'(ROWS - 1);
    localparam logic [AW-1:0] ADDR_LAST  = AW'(DEPTH - 1);
    localparam logic [AW-1:0] ROW_STRIDE = AW'(COLS);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_OP,
        ST_READ,
        ST_SCAN,
        ST_DRAIN,
        ST_RESP
    } state_t;

    typedef enum logic [1:0] {
        MV_STAY,
        MV_DOWN,
        MV_LEFT,
        MV_RIGHT
    } move_t;

    state_t            state_reg;
    logic              m_tvalid_reg;
    cell_t             m_cell_reg;
    cell_t             result_reg;
    cmd_t              cmd_reg;
    logic [AW-1:0]     op_addr_reg;
    logic              op_inside_reg;
    cell_t             op_cell_reg;
    logic              bank_reg;
    logic [AW-1:0]     clr_addr_reg;
    logic [RW-1:0]     scan_row_reg;
    logic [SW-1:0]     scan_slot_reg;
    logic [AW-1:0]     scan_base_reg;
    logic [SEED_W-1:0] lfsr_reg;

    logic              p1_valid_reg;
    logic [SW-1:0]     p1_slot_reg;
    logic              p1_first_reg;
    logic              p1_last_reg;
    logic [AW-1:0]     p1_addr_reg;

    cell_t             win_cell_reg;
    logic              win_inc_reg;
    cell_t             win_below_reg;
    cell_t             win_below2_reg;
    logic [AW-1:0]     win_addr_reg;
    move_t             mv1_reg;
    move_t             mv2_reg;

    cell_t             grid0_mem [DEPTH];
    cell_t             grid1_mem [DEPTH];
    logic              lbuf_mem  [COLS];
    cell_t             rd0_a_reg;
    cell_t             rd0_b_reg;
    cell_t             rd1_a_reg;
    cell_t             rd1_b_reg;
    logic              lb_rd_reg;

    cmd_t              in_cmd;
    logic [ROW_W-1:0]  in_row;
    logic [COL_W-1:0]  in_col;
    cell_t             in_cell;
    logic [AW-1:0]     host_addr;
    logic              in_inside;

    logic              issue;
    logic              slot_real;
    logic              below_real;
    logic [AW-1:0]     scan_addr_a;
    logic [AW-1:0]     scan_addr_b;
    logic [AW-1:0]     rd_addr_a;
    logic [AW-1:0]     rd_addr_b;
    logic [LW-1:0]     lb_raddr;

    cell_t             cur_a;
    cell_t             cur_b;
    logic              p1_dummy;
    cell_t             s1_cell;
    cell_t             s1_below;
    logic              s1_inc;
    logic              decide;
    cell_t             nb_left;
    cell_t             nb_right;
    cell_t             first_nb;
    cell_t             second_nb;
    logic              fb;
    logic              is_sand;
    logic              blocked;
    move_t             mv;
    logic              lfsr_step;
    cell_t             next_cell;
    logic              scan_we;
    logic              lb_we;
    logic [LW-1:0]     lb_waddr;
    logic              lb_wbit;

    logic              wr_en;
    logic              wr_bank;
    logic [AW-1:0]     wr_addr;
    cell_t             wr_cell;

    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {(M_TDATA_W - CELL_W)'(0), m_cell_reg};
    assign cfg_ready = 1'b1;

    assign in_cmd    = cmd_t'(s_tuser);
    assign in_row    = s_tdata[ROW_W-1:0];
    assign in_col    = s_tdata[ROW_W +: COL_W];
    assign in_cell   = cell_t'(s_tdata[ROW_W + COL_W +: CELL_W]);
    assign host_addr = AW'(32'(in_row) * COLS + 32'(in_col));
    assign in_inside = (32'(in_row) < ROWS) && (32'(in_col) < COLS);

    assign issue       = (state_reg == ST_SCAN);
    assign slot_real   = (scan_slot_reg < SLOT_COLS);
    assign below_real  = slot_real && (scan_row_reg != ROW_LAST);
    assign scan_addr_a = scan_base_reg + AW'(scan_slot_reg);
    assign scan_addr_b = scan_addr_a + ROW_STRIDE;

    always_comb begin
        rd_addr_a = '0;
        if (state_reg == ST_OP && op_inside_reg) begin
            rd_addr_a = op_addr_reg;
        end else if (issue && slot_real) begin
            rd_addr_a = scan_addr_a;
        end
    end

    assign rd_addr_b = (issue && below_real) ? scan_addr_b : '0;
    assign lb_raddr  = (issue && slot_real) ? scan_slot_reg[LW-1:0] : '0;

    assign cur_a    = bank_reg ? rd1_a_reg : rd0_a_reg;
    assign cur_b    = bank_reg ? rd1_b_reg : rd0_b_reg;
    assign p1_dummy = (p1_slot_reg >= SLOT_COLS);
    assign s1_cell  = p1_dummy ? CELL_EMPTY : cur_a;
    assign s1_below = (p1_dummy || p1_last_reg) ? CELL_INERT : cur_b;
    assign s1_inc   = !p1_dummy && !p1_first_reg && lb_rd_reg;

    assign decide    = p1_valid_reg && (p1_slot_reg != '0);
    assign nb_left   = (p1_slot_reg == SLOT_ONE) ? CELL_INERT : win_below2_reg;
    assign nb_right  = s1_below;
    assign fb        = lfsr_reg[0] ^ lfsr_reg[2] ^ lfsr_reg[3] ^ lfsr_reg[5];
    assign first_nb  = fb ? nb_left : nb_right;
    assign second_nb = fb ? nb_right : nb_left;
    assign is_sand   = (win_cell_reg == CELL_SAND);
    assign blocked   = (win_below_reg != CELL_EMPTY);
    assign lfsr_step = decide && is_sand && blocked;

    always_comb begin
        mv = MV_STAY;
        if (is_sand) begin
            if (!blocked) begin
                mv = MV_DOWN;
            end else if (first_nb == CELL_EMPTY) begin
                mv = fb ? MV_LEFT : MV_RIGHT;
            end else if (second_nb == CELL_EMPTY) begin
                mv = fb ? MV_RIGHT : MV_LEFT;
            end
        end
    end

    always_comb begin
        next_cell = win_cell_reg;
        if (win_inc_reg) begin
            next_cell = CELL_SAND;
        end else if (is_sand && mv != MV_STAY) begin
            next_cell = CELL_EMPTY;
        end
    end

    assign scan_we  = decide && (p1_slot_reg != SLOT_LAST);
    assign lb_we    = p1_valid_reg && (p1_slot_reg >= SLOT_TWO);
    assign lb_waddr = LW'(p1_slot_reg - SLOT_TWO);
    assign lb_wbit  = (mv2_reg == MV_RIGHT) || (mv1_reg == MV_DOWN) || (mv == MV_LEFT);

    always_comb begin
        wr_en   = 1'b0;
        wr_bank = bank_reg;
        wr_addr = '0;
        wr_cell = CELL_EMPTY;
        if (state_reg == ST_CLEAR) begin
            wr_en   = 1'b1;
            wr_addr = clr_addr_reg;
        end else if (state_reg == ST_OP && cmd_reg == CMD_WRITE && op_inside_reg) begin
            wr_en   = 1'b1;
            wr_addr = op_addr_reg;
            wr_cell = op_cell_reg;
        end else if (scan_we) begin
            wr_en   = 1'b1;
            wr_bank = !bank_reg;
            wr_addr = win_addr_reg;
            wr_cell = next_cell;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en && !wr_bank) begin
            grid0_mem[wr_addr] <= wr_cell;
        end
        rd0_a_reg <= grid0_mem[rd_addr_a];
        rd0_b_reg <= grid0_mem[rd_addr_b];
    end

    always_ff @(posedge aclk) begin
        if (wr_en && wr_bank) begin
            grid1_mem[wr_addr] <= wr_cell;
        end
        rd1_a_reg <= grid1_mem[rd_addr_a];
        rd1_b_reg <= grid1_mem[rd_addr_b];
    end

    always_ff @(posedge aclk) begin
        if (lb_we) begin
            lbuf_mem[lb_waddr] <= lb_wbit;
        end
        lb_rd_reg <= lbuf_mem[lb_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else begin
            p1_valid_reg <= issue;
        end
        p1_slot_reg  <= scan_slot_reg;
        p1_first_reg <= (scan_row_reg == '0);
        p1_last_reg  <= (scan_row_reg == ROW_LAST);
        p1_addr_reg  <= scan_addr_a;
    end

    always_ff @(posedge aclk) begin
        if (p1_valid_reg) begin
            win_cell_reg   <= s1_cell;
            win_inc_reg    <= s1_inc;
            win_below2_reg <= win_below_reg;
            win_below_reg  <= s1_below;
            win_addr_reg   <= p1_addr_reg;
            if (p1_slot_reg == '0) begin
                mv1_reg <= MV_STAY;
                mv2_reg <= MV_STAY;
            end else begin
                mv1_reg <= mv;
                mv2_reg <= mv1_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lfsr_reg <= LFSR_ONE;
        end else if (cfg_valid) begin
            lfsr_reg <= (cfg_data == '0) ? LFSR_ONE : cfg_data;
        end else if (lfsr_step) begin
            lfsr_reg <= {fb, lfsr_reg[SEED_W-1:1]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            m_tvalid_reg <= 1'b0;
            bank_reg     <= 1'b0;
            clr_addr_reg <= '0;
        end else begin
            if (m_tvalid_reg && m_tready && state_reg != ST_RESP) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR: begin
                    clr_addr_reg <= clr_addr_reg + AW'(1);
                    if (clr_addr_reg == ADDR_LAST) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_tvalid) begin
                        cmd_reg       <= in_cmd;
                        op_addr_reg   <= host_addr;
                        op_inside_reg <= in_inside;
                        op_cell_reg   <= in_cell;
                        result_reg    <= CELL_EMPTY;
                        scan_row_reg  <= '0;
                        scan_slot_reg <= '0;
                        scan_base_reg <= '0;
                        case (in_cmd)
                            CMD_WRITE: state_reg <= ST_OP;
                            CMD_READ:  state_reg <= ST_OP;
                            CMD_STEP:  state_reg <= ST_SCAN;
                            default:   state_reg <= ST_RESP;
                        endcase
                    end
                end
                ST_OP: begin
                    state_reg <= (cmd_reg == CMD_READ) ? ST_READ : ST_RESP;
                end
                ST_READ: begin
                    if (op_inside_reg) begin
                        result_reg <= cur_a;
                    end
                    state_reg <= ST_RESP;
                end
                ST_SCAN: begin
                    if (scan_slot_reg == SLOT_LAST) begin
                        scan_slot_reg <= '0;
                        scan_row_reg  <= scan_row_reg + RW'(1);
                        scan_base_reg <= scan_base_reg + ROW_STRIDE;
                        if (scan_row_reg == ROW_LAST) begin
                            state_reg <= ST_DRAIN;
                        end
                    end else begin
                        scan_slot_reg <= scan_slot_reg + SW'(1);
                    end
                end
                ST_DRAIN: begin
                    bank_reg  <= !bank_reg;
                    state_reg <= ST_RESP;
                end
                ST_RESP: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_cell_reg   <= result_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: rtl/fsgs_checker.sv
// Port-level checker for the falling-sand grid step unit, with its bind.
// Depends on fsgs_pkg and on the port list of falling_sand_grid_step_unit.
module fsgs_checker
    import fsgs_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    logic [1:0] pending_reg;
    logic       s_take;
    logic       m_take;

    assign s_take = s_tvalid && s_tready;
    assign m_take = m_tvalid && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
        end else if (s_take && !m_take) begin
            pending_reg <= pending_reg + 2'd1;
        end else if (m_take && !s_take) begin
            pending_reg <= pending_reg - 2'd1;
        end
    end

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid straight after reset");

    a_no_spurious: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> pending_reg != 2'd0)
        else $error("result transaction without an accepted item");

    a_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        pending_reg != 2'd3)
        else $error("more than two items outstanding");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result dropped or changed");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[M_TDATA_W-1:CELL_W] == '0)
        else $error("result padding bits not zero");

endmodule

bind falling_sand_grid_step_unit fsgs_checker u_fsgs_checker (.*);
